FILE: src/u8d_pkg.sv
// shared types and constants for the utf-8 stream decoder
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int CNT_W   = 2;
    localparam int TDATA_W = 24;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = CP_W'(16'hFFFD);

    // lead byte masks and patterns
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;

    // payload masks
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

    // continuation counts opened by each lead form
    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_TWO  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_THREE = 2'd2;
    localparam logic [CNT_W-1:0] CNT_FOUR = 2'd3;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_BAD_LEAD  = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        status_t         status;
        logic            end_of_buffer;
    } result_t;

endpackage

FILE: src/u8d_core.sv
// decode state and per-byte decode logic
`timescale 1ns / 1ps

module u8d_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [u8d_pkg::BYTE_W-1:0]    byte_value,
    input  logic                          last_byte,
    output u8d_pkg::result_t              result
);
    import u8d_pkg::*;

    logic [CNT_W-1:0] bytes_remaining_reg, bytes_remaining_next;
    logic [CP_W-1:0]  value_acc_reg, value_acc_next;
    logic             broken_reg, broken_next;

    logic             is_cont;
    logic [CP_W-1:0]  acc_step;
    logic             broken_step;
    logic [CNT_W-1:0] cnt_step;

    // continuation step values
    always_comb
    begin
        is_cont     = !broken_reg && ((byte_value & CONT_MASK) == CONT_PAT);
        acc_step    = is_cont ? {value_acc_reg[CP_W-7:0], byte_value[5:0]} : value_acc_reg;
        broken_step = broken_reg | !is_cont;
        cnt_step    = bytes_remaining_reg - CNT_W'(1);
    end

    // decode one byte
    always_comb
    begin
        bytes_remaining_next = bytes_remaining_reg;
        value_acc_next       = value_acc_reg;
        broken_next          = broken_reg;
        result.valid         = 1'b0;
        result.code_point    = '0;
        result.status        = ST_VALID;
        result.end_of_buffer = last_byte;

        if (bytes_remaining_reg == CNT_NONE)
        begin
            broken_next = 1'b0;
            if (!byte_value[BYTE_W-1])
            begin
                result.valid      = 1'b1;
                result.code_point = CP_W'(byte_value);
            end
            else if ((byte_value & LEAD2_MASK) == LEAD2_PAT)
            begin
                value_acc_next       = CP_W'(byte_value & LEAD2_BITS);
                bytes_remaining_next = CNT_TWO;
            end
            else if ((byte_value & LEAD3_MASK) == LEAD3_PAT)
            begin
                value_acc_next       = CP_W'(byte_value & LEAD3_BITS);
                bytes_remaining_next = CNT_THREE;
            end
            else if ((byte_value & LEAD4_MASK) == LEAD4_PAT)
            begin
                value_acc_next       = CP_W'(byte_value & LEAD4_BITS);
                bytes_remaining_next = CNT_FOUR;
            end
            else
            begin
                result.valid      = 1'b1;
                result.code_point = CP_REPLACEMENT;
                result.status     = ST_BAD_LEAD;
            end
            // lead byte cut off by end of buffer
            if (!result.valid && last_byte)
            begin
                result.valid  = 1'b1;
                result.status = ST_TRUNCATED;
            end
        end
        else
        begin
            value_acc_next       = acc_step;
            broken_next          = broken_step;
            bytes_remaining_next = cnt_step;
            if (cnt_step == CNT_NONE)
            begin
                result.valid      = 1'b1;
                result.code_point = acc_step;
                result.status     = broken_step ? ST_MALFORMED : ST_VALID;
            end
            else if (last_byte)
            begin
                result.valid  = 1'b1;
                result.status = ST_TRUNCATED;
            end
        end

        // any result closes the sequence
        if (result.valid)
        begin
            bytes_remaining_next = CNT_NONE;
            value_acc_next       = '0;
            broken_next          = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_remaining_reg <= CNT_NONE;
            value_acc_reg       <= '0;
            broken_reg          <= 1'b0;
        end
        else if (fire)
        begin
            bytes_remaining_reg <= bytes_remaining_next;
            value_acc_reg       <= value_acc_next;
            broken_reg          <= broken_next;
        end
    end

    // a buffer boundary leaves no sequence open
    a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_byte |=> bytes_remaining_reg == CNT_NONE && !broken_reg)
        else $error("sequence state survived end of buffer");

    // truncation never carries partial bits
    a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_TRUNCATED |-> result.code_point == '0)
        else $error("truncated result with nonzero code point");

    // bad lead only outside an open sequence
    a_bad_lead_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_BAD_LEAD |-> bytes_remaining_reg == CNT_NONE)
        else $error("bad lead reported inside a sequence");

    // malformed result only closes a sequence
    a_malformed_src: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_MALFORMED |-> bytes_remaining_reg != CNT_NONE)
        else $error("malformed result without open sequence");

endmodule

FILE: src/u8d_out_reg.sv
// result register toward the output stream
`timescale 1ns / 1ps

module u8d_out_reg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  u8d_pkg::result_t                  result,
    output logic                              can_load,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [u8d_pkg::TDATA_W-1:0]       m_axis_tdata,  // code_point [20:0], zero fill
    output logic [1:0]                        m_axis_tuser,  // status [1:0]
    output logic                              m_axis_tlast
);
    import u8d_pkg::*;

    logic            valid_reg;
    logic [CP_W-1:0] cp_reg;
    status_t         status_reg;
    logic            eob_reg;

    // register is free when empty or being drained this cycle
    assign can_load = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            cp_reg     <= result.code_point;
            status_reg <= result.status;
            eob_reg    <= result.end_of_buffer;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = TDATA_W'(cp_reg);
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = eob_reg;

endmodule

FILE: src/utf8_stream_decoder.sv
// top level of the utf-8 stream decoder
`timescale 1ns / 1ps

// Decodes a byte stream of UTF-8 into code points.
// Input stream: one byte per item on s_axis_tdata, s_axis_tlast marks the
// final byte of a buffer. Output stream: code point on m_axis_tdata[20:0],
// status on m_axis_tuser (0 valid, 1 bad lead, 2 malformed, 3 truncated),
// m_axis_tlast set when the result came from the final byte of a buffer.
// Lead and inner continuation bytes give no result; the closing byte of a
// sequence, an ASCII byte, a bad lead or a cut-off sequence gives one.
// Throughput: one byte per cycle while the receiver takes results. The decode is one short level
// of logic between an input register and a result register.
// A closing byte is accepted into the input register, decoded there, and its
// result is loaded into the result register that drives the output stream.
// Reset clears both registers and the open sequence state; the stream
// starts a new buffer. When the receiver stalls, the result register holds
// its item, the input register fills behind it and s_axis_tready drops;
// nothing is lost or repeated. The byte after a tlast byte always starts
// a fresh buffer.
module utf8_stream_decoder
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // byte_value [7:0]
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [u8d_pkg::TDATA_W-1:0]   m_axis_tdata,  // code_point [20:0], zero fill
    output logic [1:0]                    m_axis_tuser,  // status [1:0]
    output logic                          m_axis_tlast
);
    import u8d_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              advance;
    logic              out_can_load;
    result_t           result;

    // held byte moves on unless its result would hit a full output
    assign advance       = in_valid_reg && (!result.valid || out_can_load);
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    u8d_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .byte_value (in_byte_reg),
        .last_byte  (in_last_reg),
        .result     (result)
    );

    u8d_out_reg u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && result.valid),
        .result        (result),
        .can_load      (out_can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // a stalled byte stays in the input register
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input byte dropped while stalled");

    // a byte that gives a result only moves into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.valid |-> !m_axis_tvalid || m_axis_tready)
        else $error("result register overwritten");

    // tlast result always ends a buffer in the input byte
    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.valid |-> result.end_of_buffer == in_last_reg)
        else $error("end of buffer flag mismatch");

endmodule

FILE: bench/tb_utf8_stream_decoder.sv
// self-checking testbench for the utf-8 stream decoder
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;

    import u8d_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 680;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_START    = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int DIRECTED_LEN  = 24;

    // one decoded result as the block should give it
    typedef struct {
        logic [CP_W-1:0] code_point;
        status_t         status;
        logic            end_of_buffer;
    } decoded_t;

    // predictor of the decoder and store of code points still to come
    class utf8_scoreboard;
        logic [CNT_W-1:0] remaining;
        logic [CP_W-1:0]  acc;
        logic             broken;
        decoded_t         expected_points[$];
        int               errors;

        function new();
            clear_sequence();
            errors = 0;
        endfunction

        function void clear_sequence();
            remaining = CNT_NONE;
            acc       = '0;
            broken    = 1'b0;
        endfunction

        function void push_point(logic [CP_W-1:0] cp, status_t st, logic eob);
            decoded_t d;
            d.code_point    = cp;
            d.status        = st;
            d.end_of_buffer = eob;
            expected_points.push_back(d);
            clear_sequence();
        endfunction

        // update the predicted state with one accepted byte
        function void note_byte(logic [BYTE_W-1:0] b_val, logic last);
            if (remaining == CNT_NONE) begin
                broken = 1'b0;
                if (!b_val[BYTE_W-1]) begin
                    push_point(CP_W'(b_val), ST_VALID, last);
                end
                else if ((b_val & LEAD2_MASK) == LEAD2_PAT) begin
                    acc       = CP_W'(b_val & LEAD2_BITS);
                    remaining = CNT_TWO;
                end
                else if ((b_val & LEAD3_MASK) == LEAD3_PAT) begin
                    acc       = CP_W'(b_val & LEAD3_BITS);
                    remaining = CNT_THREE;
                end
                else if ((b_val & LEAD4_MASK) == LEAD4_PAT) begin
                    acc       = CP_W'(b_val & LEAD4_BITS);
                    remaining = CNT_FOUR;
                end
                else begin
                    push_point(CP_REPLACEMENT, ST_BAD_LEAD, last);
                end
                // lead byte cut off by the end of the buffer
                if (remaining != CNT_NONE && last)
                    push_point('0, ST_TRUNCATED, 1'b1);
            end
            else begin
                if (!broken && (b_val & CONT_MASK) == CONT_PAT)
                    acc = (acc << 6) | CP_W'(b_val & CONT_BITS);
                else
                    broken = 1'b1;
                remaining = remaining - 1'b1;
                if (remaining == CNT_NONE)
                    push_point(acc, broken ? ST_MALFORMED : ST_VALID, last);
                else if (last)
                    push_point('0, ST_TRUNCATED, 1'b1);
            end
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(logic [CP_W-1:0] cp, status_t st, logic eob);
            decoded_t d;
            if (expected_points.size() == 0) begin
                $error("unexpected result: code_point %h status %0d end_of_buffer %0b",
                       cp, st, eob);
                errors++;
                return;
            end
            d = expected_points.pop_front();
            if (cp !== d.code_point) begin
                $error("code_point mismatch: expected %h, actual %h", d.code_point, cp);
                errors++;
            end
            if (st !== d.status) begin
                $error("status mismatch: expected %0d, actual %0d", d.status, st);
                errors++;
            end
            if (eob !== d.end_of_buffer) begin
                $error("end_of_buffer mismatch: expected %0b, actual %0b",
                       d.end_of_buffer, eob);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [1:0]          m_axis_tuser;
    logic                m_axis_tlast;

    utf8_scoreboard sb = new();
    int  sender_idle_pct = 21;
    int  recv_idle_pct   = 80;
    int  sent_count      = 0;
    int  cycle_count     = 0;
    logic hold_off       = 1'b0;

    // {last, byte} pairs for the directed part
    logic [8:0] directed_items [DIRECTED_LEN] = '{
        9'h000, 9'h17F,                         // ascii extremes, end of buffer
        9'h0C2, 9'h0A9,                         // two-byte form
        9'h0E2, 9'h082, 9'h0AC,                 // three-byte form
        9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,         // widest four-byte value
        9'h080, 9'h0F8, 9'h1FF,                 // bad leads
        9'h1C3,                                 // lead byte at end of buffer
        9'h0E2, 9'h182,                         // sequence cut off mid-way
        9'h0E2, 9'h041, 9'h041,                 // non-continuation inside sequence
        9'h0F0, 9'h090, 9'h0C0, 9'h080          // continuation after a break adds nothing
    };

    utf8_stream_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always #HALF_PERIOD clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver ready with random stalls
    always @(posedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one long receiver stall so the block fills and backs up its input
    initial
    begin
        @(posedge clk iff rst_n);
        repeat (HOLD_START) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // monitor both handshakes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[CP_W-1:0], status_t'(m_axis_tuser),
                                m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    // offer one item and wait until it is taken
    task automatic send_byte(input logic [7:0] b_val, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b_val;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sent_count++;
    endtask

    // one random group: mostly well-formed characters, some noise,
    // broken and cut-off sequences
    task automatic send_random_group();
        logic [7:0] seq [4];
        logic [7:0] r;
        int len;
        int last_at;
        int pick;
        int k;
        pick    = $urandom_range(99);
        len     = (pick < 10) ? 1 : 1 + $urandom_range(3);
        if (pick >= 80 && len == 1)
            len = 2;
        case (len)
            1: seq[0] = {1'b0, 7'($urandom)};
            2: seq[0] = {3'b110, 5'($urandom)};
            3: seq[0] = {4'b1110, 4'($urandom)};
            default: seq[0] = {5'b11110, 3'($urandom)};
        endcase
        for (k = 1; k < 4; k++)
            seq[k] = {2'b10, 6'($urandom)};
        last_at = ($urandom_range(9) == 0) ? len - 1 : -1;
        if (pick < 10)
        begin
            // noise byte, bad leads included
            seq[0]  = 8'($urandom);
            last_at = ($urandom_range(19) == 0) ? 0 : -1;
        end
        else if (pick >= 80 && pick < 90)
        begin
            // a non-continuation byte inside the sequence
            k = $urandom_range(len - 1, 1);
            r = 8'($urandom);
            if ((r & CONT_MASK) == CONT_PAT)
                r[6] = 1'b1;
            seq[k] = r;
        end
        else if (pick >= 90)
        begin
            // end of buffer before the sequence closes
            k       = $urandom_range(len - 2, 0);
            len     = k + 1;
            last_at = k;
        end
        for (k = 0; k < len; k++)
            send_byte(seq[k], k == last_at);
    endtask

    // stimulus and end of run
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_items[i])
            send_byte(directed_items[i][7:0], directed_items[i][8]);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 21;
                    recv_idle_pct   = 80;
                end
                1:
                begin
                    sender_idle_pct = 80;
                    recv_idle_pct   = 21;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    recv_idle_pct   = 0;
                end
            endcase
            while (sent_count < DIRECTED_LEN + (phase + 1) * RANDOM_ITEMS / 3)
                send_random_group();
        end
        s_axis_tvalid <= 1'b0;

        // wait for every expected result, then watch for strays
        do
            @(posedge clk);
        while (sb.expected_points.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.expected_points.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
src/u8d_pkg.sv
src/u8d_core.sv
src/u8d_out_reg.sv
src/utf8_stream_decoder.sv
bench/tb_utf8_stream_decoder.sv
